>>> design/twmh_pkg.sv
// shared types and constants for the two-walker meeting histogram
package twmh_pkg;

    localparam int STEP_W      = 17;
    localparam int GRID_W      = 9;
    localparam int OUT_POS_W   = 8;
    localparam int OUT_COUNT_W = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam int GRID_RESET       = 100;
    localparam int STEP_LIMIT_RESET = 100000;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic REG_GRID_SIZE  = 1'b0;
    localparam logic REG_STEP_LIMIT = 1'b1;

    localparam logic [1:0] DIR_COL_INC = 2'd0;
    localparam logic [1:0] DIR_COL_DEC = 2'd1;
    localparam logic [1:0] DIR_ROW_INC = 2'd2;
    localparam logic [1:0] DIR_ROW_DEC = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [1:0]        first_direction;
        logic [1:0]        second_direction;
        logic [STEP_W-1:0] bin_index;
    } t_in;

    typedef struct packed {
        logic [OUT_POS_W-1:0]   first_row;
        logic [OUT_POS_W-1:0]   first_col;
        logic [OUT_POS_W-1:0]   second_row;
        logic [OUT_POS_W-1:0]   second_col;
        logic [STEP_W-1:0]      step_number;
        logic                   walkers_met;
        logic                   walk_ended;
        logic [OUT_COUNT_W-1:0] bin_count;
        logic [OUT_COUNT_W-1:0] samples_done;
    } t_out;

endpackage

>>> design/two_walker_meeting_histogram.sv
// top level: two-walker meeting-time histogram with histogram memory
//
// Input channel (i_valid / o_stall, payload i_data) carries one item per
// transfer: a step that moves both walkers, or a read of one histogram bin.
// Output channel (o_valid / i_stall, payload o_data) returns one result per
// input item, in order.
// Each item reads one histogram bin in the cycle of the input transfer; a
// step that does not end in a meeting writes the bin back in the next
// cycle, with forwarding when the following item touches the same bin.
// Throughput is one item per clock while the input is not stalled; a result
// passes the read-modify-write stage and the output buffer before it is offered.
// Results queue in a four-entry output buffer, so input keeps flowing while
// the receiver stalls; outside the clearing pass the input stalls only when
// the buffer and the read-modify-write stage together hold four results.
// After reset the histogram is cleared one bin per cycle, through every bin,
// while the input channel is stalled; configuration writes are taken then.
// Configuration (APB, pready always high): grid_size at 0x0, step_limit at
// 0x4. Writing grid_size sends both walkers back to the centre.
module two_walker_meeting_histogram #(
    parameter int HIST_DEPTH  = 131072,
    parameter int MAX_GRID    = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  twmh_pkg::t_in                       i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output twmh_pkg::t_out                      o_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [twmh_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [twmh_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [twmh_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import twmh_pkg::*;

    localparam int HA         = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int POS_W      = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int CMP_W      = ((POS_W > GRID_W) ? POS_W : GRID_W) + 1;
    localparam int SIDE_RST   = (GRID_RESET > MAX_GRID) ? MAX_GRID : GRID_RESET;
    localparam int CENTER_RST = SIDE_RST / 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FC_W       = FP_W + 1;

    typedef logic [POS_W-1:0] t_pos;

    function automatic logic [GRID_W-1:0] side_of(input logic [GRID_W-1:0] g);
        logic [GRID_W-1:0] s;
        if (g < GRID_W'(2)) begin
            s = GRID_W'(2);
        end else if (32'(g) > MAX_GRID) begin
            s = GRID_W'(MAX_GRID);
        end else begin
            s = g;
        end
        return s;
    endfunction

    function automatic t_pos step_up(input t_pos p, input logic [GRID_W-1:0] n);
        t_pos q;
        if (CMP_W'(p) + CMP_W'(1) < CMP_W'(n)) begin
            q = p + t_pos'(1);
        end else if (p == '0) begin
            q = '0;
        end else begin
            q = p - t_pos'(1);
        end
        return q;
    endfunction

    function automatic t_pos step_down(input t_pos p, input logic [GRID_W-1:0] n);
        t_pos q;
        if (p != '0) begin
            q = p - t_pos'(1);
        end else if (n > GRID_W'(1)) begin
            q = t_pos'(1);
        end else begin
            q = '0;
        end
        return q;
    endfunction

    function automatic logic [2*POS_W-1:0] move(input t_pos row, input t_pos col,
                                               input logic [1:0] dir,
                                               input logic [GRID_W-1:0] n);
        t_pos r;
        t_pos c;
        r = row;
        c = col;
        unique case (dir)
            DIR_COL_INC: c = step_up(col, n);
            DIR_COL_DEC: c = step_down(col, n);
            DIR_ROW_INC: r = step_up(row, n);
            DIR_ROW_DEC: r = step_down(row, n);
            default:     r = row;
        endcase
        return {r, c};
    endfunction

    // configuration and walk state
    logic [GRID_W-1:0]      r_grid_size;
    logic [STEP_W-1:0]      r_step_limit;
    t_pos                   r_first_row, r_first_col, r_second_row, r_second_col;
    t_pos                   n_first_row, n_first_col, n_second_row, n_second_col;
    logic [STEP_W-1:0]      r_step, n_step;
    logic [COUNT_WIDTH-1:0] r_samples, n_samples;

    // clearing pass
    logic                   r_clearing;
    logic [HA-1:0]          r_clear_addr;

    // histogram memory
    logic [COUNT_WIDTH-1:0] r_hist [HIST_DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   hist_we;
    logic [HA-1:0]          hist_waddr;
    logic [COUNT_WIDTH-1:0] hist_wdata;
    logic [HA-1:0]          hist_raddr;

    // read-modify-write stage
    logic                   r_s1_valid;
    t_out                   r_s1_res;
    logic                   r_s1_read;
    logic                   r_s1_in_range;
    logic                   r_s1_inc;
    logic [HA-1:0]          r_s1_addr;
    logic                   r_s1_fwd;
    logic [COUNT_WIDTH-1:0] r_s1_fwd_data;

    // output buffer
    t_out                   r_fifo [FIFO_DEPTH];
    logic [FP_W-1:0]        r_wptr, r_rptr;
    logic [FC_W-1:0]        r_cnt, n_cnt;

    logic                   cfg_write;
    logic                   accept;
    logic                   pop;
    logic [GRID_W-1:0]      side;
    t_pos                   center;
    logic [GRID_W-1:0]      new_side;
    t_pos                   new_center;
    logic [2*POS_W-1:0]     first_moved, second_moved;
    t_pos                   fr, fc, sr, sc;
    logic                   is_read;
    logic                   met, ended, do_inc, in_range;
    logic [STEP_W-1:0]      addr_sel;
    logic [COUNT_WIDTH-1:0] samples_after;
    t_out                   s0_res;
    logic [COUNT_WIDTH-1:0] cur, bumped;
    t_out                   s1_res;
    logic [FC_W-1:0]        occupancy;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_GRID_SIZE:  prdata = APB_DATA_W'(r_grid_size);
            REG_STEP_LIMIT: prdata = APB_DATA_W'(r_step_limit);
            default:        prdata = '0;
        endcase
    end

    assign occupancy = r_cnt + FC_W'(r_s1_valid);
    assign o_stall   = r_clearing || (occupancy > FC_W'(FIFO_DEPTH - 1));
    assign accept    = i_valid && !o_stall;

    assign side       = side_of(r_grid_size);
    assign center     = t_pos'(side[GRID_W-1:1]);
    assign new_side   = side_of(pwdata[GRID_W-1:0]);
    assign new_center = t_pos'(new_side[GRID_W-1:1]);

    // walker moves and walk end decision
    always_comb begin
        is_read      = (i_data.operation == OP_READ);
        first_moved  = move(r_first_row, r_first_col, i_data.first_direction, side);
        second_moved = move(r_second_row, r_second_col, i_data.second_direction, side);
        if (is_read) begin
            fr = r_first_row;
            fc = r_first_col;
            sr = r_second_row;
            sc = r_second_col;
        end else begin
            {fr, fc} = first_moved;
            {sr, sc} = second_moved;
        end
        met      = !is_read && (r_step != '0) && (fr == sr) && (fc == sc);
        ended    = !is_read && (met || (r_step >= r_step_limit));
        addr_sel = is_read ? i_data.bin_index : r_step;
        in_range = (32'(addr_sel) < HIST_DEPTH);
        do_inc   = !is_read && !met && in_range;
        samples_after = ended ? r_samples + COUNT_WIDTH'(1) : r_samples;

        s0_res.first_row    = OUT_POS_W'(fr);
        s0_res.first_col    = OUT_POS_W'(fc);
        s0_res.second_row   = OUT_POS_W'(sr);
        s0_res.second_col   = OUT_POS_W'(sc);
        s0_res.step_number  = r_step;
        s0_res.walkers_met  = met;
        s0_res.walk_ended   = ended;
        s0_res.bin_count    = '0;
        s0_res.samples_done = OUT_COUNT_W'(samples_after);

        n_first_row  = r_first_row;
        n_first_col  = r_first_col;
        n_second_row = r_second_row;
        n_second_col = r_second_col;
        n_step       = r_step;
        n_samples    = r_samples;
        priority if (cfg_write && paddr[2] == REG_GRID_SIZE) begin
            n_first_row  = new_center;
            n_first_col  = new_center;
            n_second_row = new_center;
            n_second_col = new_center;
            n_step       = '0;
        end else if (accept && !is_read) begin
            n_samples = samples_after;
            if (ended) begin
                n_first_row  = center;
                n_first_col  = center;
                n_second_row = center;
                n_second_col = center;
                n_step       = '0;
            end else begin
                n_first_row  = fr;
                n_first_col  = fc;
                n_second_row = sr;
                n_second_col = sc;
                n_step       = r_step + STEP_W'(1);
            end
        end else begin
            n_step = r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size  <= GRID_W'(GRID_RESET);
            r_step_limit <= STEP_W'(STEP_LIMIT_RESET);
            r_first_row  <= t_pos'(CENTER_RST);
            r_first_col  <= t_pos'(CENTER_RST);
            r_second_row <= t_pos'(CENTER_RST);
            r_second_col <= t_pos'(CENTER_RST);
            r_step       <= '0;
            r_samples    <= '0;
        end else begin
            if (cfg_write && paddr[2] == REG_GRID_SIZE) begin
                r_grid_size <= pwdata[GRID_W-1:0];
            end
            if (cfg_write && paddr[2] == REG_STEP_LIMIT) begin
                r_step_limit <= pwdata[STEP_W-1:0];
            end
            r_first_row  <= n_first_row;
            r_first_col  <= n_first_col;
            r_second_row <= n_second_row;
            r_second_col <= n_second_col;
            r_step       <= n_step;
            r_samples    <= n_samples;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clear_addr <= '0;
        end else if (r_clearing) begin
            r_clear_addr <= r_clear_addr + HA'(1);
            if (r_clear_addr == HA'(HIST_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // bin update with saturation
    assign cur    = r_s1_fwd ? r_s1_fwd_data : r_rd_data;
    assign bumped = (&cur) ? cur : cur + COUNT_WIDTH'(1);

    always_comb begin
        if (r_clearing) begin
            hist_we    = 1'b1;
            hist_waddr = r_clear_addr;
            hist_wdata = '0;
        end else begin
            hist_we    = r_s1_valid && r_s1_inc;
            hist_waddr = r_s1_addr;
            hist_wdata = bumped;
        end
        hist_raddr = HA'(addr_sel);
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[hist_waddr] <= hist_wdata;
        end
        if (accept) begin
            r_rd_data <= r_hist[hist_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res      <= s0_res;
            r_s1_read     <= is_read;
            r_s1_in_range <= in_range;
            r_s1_inc      <= do_inc;
            r_s1_addr     <= hist_raddr;
            r_s1_fwd      <= hist_we && (hist_waddr == hist_raddr);
            r_s1_fwd_data <= hist_wdata;
        end
    end

    always_comb begin
        s1_res = r_s1_res;
        if (r_s1_read && r_s1_in_range) begin
            s1_res.bin_count = OUT_COUNT_W'(cur);
        end
    end

    // output buffer
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_fifo[r_rptr];
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (r_s1_valid && !pop) begin
            n_cnt = r_cnt + FC_W'(1);
        end else if (!r_s1_valid && pop) begin
            n_cnt = r_cnt - FC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (r_s1_valid) begin
                r_wptr <= r_wptr + FP_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FP_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_fifo[r_wptr] <= s1_res;
        end
    end

endmodule

>>> design/twmh_checker.sv
// port-level checks for the two-walker meeting histogram, bound to the top level
module twmh_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input twmh_pkg::t_out                      o_data
);
    import twmh_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // input is held off right after reset, when the histogram clearing starts
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input taken right after reset");

    a_met_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.walkers_met |-> o_data.walk_ended)
        else $error("meeting without walk end");

    // no meeting is reported on the first step of a walk
    a_met_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.walkers_met |-> o_data.step_number != '0)
        else $error("meeting at step zero");

    // results that end a walk carry no bin count
    a_met_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.walk_ended |-> o_data.bin_count == '0)
        else $error("bin count on a step result");

endmodule

bind two_walker_meeting_histogram twmh_checker u_twmh_checker (.*);

>>> tb/two_walker_meeting_histogram_tb.sv
// testbench for the two-walker meeting histogram: queued stimulus, predicted results, APB setup
`timescale 1ns / 1ps

module two_walker_meeting_histogram_tb;
    import twmh_pkg::*;

    localparam int N_PHASES       = 9;
    localparam int PHASE_ITEMS    = 95;
    localparam int HOLD_PHASE     = 3;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 10;
    localparam int BIN_MAX        = 131071;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in                   i_data  = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out                  o_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    two_walker_meeting_histogram i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // predicted block state
    logic [GRID_W-1:0] grid_reg;
    logic [STEP_W-1:0] limit_reg;
    logic [8:0]        w1_row, w1_col, w2_row, w2_col;
    logic [STEP_W-1:0] walk_step;
    int unsigned       walks_done;
    int unsigned       survival [int unsigned];

    t_in  pending_items [$];
    t_out expected_results [$];

    int   errors     = 0;
    int   n_steps    = 0;
    int   n_reads    = 0;
    int   n_ended    = 0;
    int   n_met      = 0;
    int   n_writes   = 0;
    bit   tx_idle_on = 1'b0;
    bit   rx_idle_on = 1'b0;
    bit   hold_trigger = 1'b0;
    bit   hold_used  = 1'b0;
    int   hold_left  = 0;
    int   tx_gap     = 0;
    int   next_gap;
    int   rx_wait    = 0;

    int phase_grid  [N_PHASES] = '{2, 511, 3, 256, 5, 1, 12, 0, 100};
    int phase_limit [N_PHASES] = '{0, 131071, 7, 40, 200, 131071, 25, 15, 100000};
    bit phase_tx    [N_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    bit phase_rx    [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    function automatic logic [8:0] grid_side();
        if (grid_reg < 2) return 9'd2;
        if (grid_reg > 256) return 9'd256;
        return grid_reg;
    endfunction

    function automatic void recentre();
        logic [8:0] c;
        c = grid_side() >> 1;
        w1_row = c;
        w1_col = c;
        w2_row = c;
        w2_col = c;
        walk_step = '0;
    endfunction

    function automatic logic [8:0] shift_coord(logic [8:0] p, bit up, logic [8:0] n);
        if (up) return (p + 9'd1 < n) ? p + 9'd1 : ((p == 0) ? 9'd0 : p - 9'd1);
        return (p > 0) ? p - 9'd1 : 9'd1;
    endfunction

    function automatic void move_walker(inout logic [8:0] row, inout logic [8:0] col,
                                        input logic [1:0] dir, input logic [8:0] n);
        case (dir)
            DIR_COL_INC: col = shift_coord(col, 1'b1, n);
            DIR_COL_DEC: col = shift_coord(col, 1'b0, n);
            DIR_ROW_INC: row = shift_coord(row, 1'b1, n);
            default:     row = shift_coord(row, 1'b0, n);
        endcase
    endfunction

    function automatic void model_config(logic idx, logic [31:0] value);
        if (idx == REG_GRID_SIZE) begin
            grid_reg = value[GRID_W-1:0];
            recentre();
        end else begin
            limit_reg = value[STEP_W-1:0];
        end
    endfunction

    function automatic t_out predict_walk(t_in it);
        t_out              r;
        logic [8:0]        n;
        logic [STEP_W-1:0] j;
        bit                met;
        bit                ended;
        int unsigned       cnt;
        r = '0;
        n = grid_side();
        j = walk_step;
        met = 1'b0;
        ended = 1'b0;
        if (it.operation == OP_READ) begin
            n_reads++;
            r.bin_count = survival.exists(it.bin_index) ? survival[it.bin_index] : 0;
        end else begin
            n_steps++;
            move_walker(w1_row, w1_col, it.first_direction, n);
            move_walker(w2_row, w2_col, it.second_direction, n);
            if (j != 0 && w1_row == w2_row && w1_col == w2_col) begin
                met = 1'b1;
                ended = 1'b1;
            end else begin
                cnt = survival.exists(j) ? survival[j] : 0;
                if (cnt != 32'hFFFF_FFFF) survival[j] = cnt + 1;
                if (j >= limit_reg) ended = 1'b1;
            end
        end
        r.first_row   = w1_row[7:0];
        r.first_col   = w1_col[7:0];
        r.second_row  = w2_row[7:0];
        r.second_col  = w2_col[7:0];
        r.step_number = j;
        r.walkers_met = met;
        r.walk_ended  = ended;
        if (it.operation == OP_STEP) begin
            if (ended) begin
                walks_done++;
                n_ended++;
                if (met) n_met++;
                recentre();
            end else begin
                walk_step = j + 1'b1;
            end
        end
        r.samples_done = walks_done;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else if (i_valid && !o_stall) begin
            expected_results.insert(expected_results.size(), predict_walk(i_data));
            next_gap = tx_idle_on ? $urandom_range(0, 19) : 0;
            if (next_gap == 0 && pending_items.size() != 0) begin
                i_data <= pending_items.pop_front();
            end else begin
                i_valid <= 1'b0;
                tx_gap  <= next_gap;
            end
        end else if (!i_valid) begin
            if (tx_gap != 0) begin
                tx_gap <= tx_gap - 1;
            end else if (pending_items.size() != 0) begin
                i_valid <= 1'b1;
                i_data  <= pending_items.pop_front();
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_trigger && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result");
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("first_row", exp_r.first_row, o_data.first_row);
                    check_field("first_col", exp_r.first_col, o_data.first_col);
                    check_field("second_row", exp_r.second_row, o_data.second_row);
                    check_field("second_col", exp_r.second_col, o_data.second_col);
                    check_field("step_number", exp_r.step_number, o_data.step_number);
                    check_field("walkers_met", exp_r.walkers_met, o_data.walkers_met);
                    check_field("walk_ended", exp_r.walk_ended, o_data.walk_ended);
                    check_field("bin_count", exp_r.bin_count, o_data.bin_count);
                    check_field("samples_done", exp_r.samples_done, o_data.samples_done);
                end
                rx_wait = rx_idle_on ? $urandom_range(0, 19) : 0;
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            i_stall <= (rx_wait != 0) || (hold_left != 0);
        end
    end

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || i_valid || expected_results.size() != 0);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] value);
        logic [31:0] rd_exp;
        wait_idle();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_config(idx, value);
        n_writes++;
        @(negedge i_clk);
        // register readback on the same address
        if (idx == REG_GRID_SIZE) begin
            rd_exp = 32'(value[GRID_W-1:0]);
        end else begin
            rd_exp = 32'(value[STEP_W-1:0]);
        end
        check_field("pready", 64'(1'b1), 64'(pready));
        check_field("prdata", 64'(rd_exp), 64'(prdata));
    endtask

    task automatic push_step(input logic [1:0] d1, input logic [1:0] d2);
        t_in it;
        it = '0;
        it.operation        = OP_STEP;
        it.first_direction  = d1;
        it.second_direction = d2;
        it.bin_index        = $urandom_range(0, BIN_MAX);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_read(input logic [STEP_W-1:0] idx);
        t_in it;
        it.operation        = OP_READ;
        it.first_direction  = $urandom_range(0, 3);
        it.second_direction = $urandom_range(0, 3);
        it.bin_index        = idx;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_random();
        if ($urandom_range(0, 99) < 15) begin
            if ($urandom_range(0, 9) == 0) push_read($urandom_range(0, BIN_MAX));
            else push_read($urandom_range(0, 63));
        end else begin
            push_step($urandom_range(0, 3), $urandom_range(0, 3));
        end
    endtask

    initial begin
        grid_reg   = GRID_RESET;
        limit_reg  = STEP_LIMIT_RESET;
        walks_done = 0;
        recentre();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: meeting, coincidence at step zero, reads
        push_step(DIR_COL_INC, DIR_COL_DEC);
        push_step(DIR_COL_DEC, DIR_COL_INC);
        push_step(DIR_ROW_INC, DIR_ROW_INC);
        push_step(DIR_ROW_DEC, DIR_ROW_INC);
        push_read(17'd0);
        push_read(17'd1);
        push_read(17'h1FFFF);

        // undersized grid, zero step limit, wall reflection
        cfg_write(REG_GRID_SIZE, 32'd0);
        cfg_write(REG_STEP_LIMIT, 32'd0);
        push_step(DIR_COL_INC, DIR_ROW_DEC);
        push_step(DIR_ROW_INC, DIR_COL_DEC);

        // oversized grid, then step limit lowered mid-walk
        cfg_write(REG_GRID_SIZE, 32'd511);
        cfg_write(REG_STEP_LIMIT, 32'd131071);
        push_step(DIR_COL_INC, DIR_ROW_INC);
        push_step(DIR_ROW_DEC, DIR_COL_DEC);
        push_step(DIR_COL_DEC, DIR_ROW_DEC);
        push_step(DIR_ROW_INC, DIR_COL_INC);
        cfg_write(REG_STEP_LIMIT, 32'd2);
        push_step(DIR_COL_INC, DIR_COL_INC);
        push_step(DIR_ROW_INC, DIR_ROW_DEC);
        push_step(DIR_COL_DEC, DIR_ROW_INC);

        // grid rewritten mid-walk
        cfg_write(REG_GRID_SIZE, 32'd257);
        push_step(DIR_ROW_DEC, DIR_ROW_DEC);
        cfg_write(REG_GRID_SIZE, 32'd1);
        cfg_write(REG_STEP_LIMIT, 32'd3);
        push_step(DIR_ROW_INC, DIR_COL_INC);
        push_step(DIR_COL_DEC, DIR_ROW_DEC);
        push_step(DIR_ROW_DEC, DIR_COL_INC);
        push_step(DIR_COL_INC, DIR_ROW_INC);
        push_read(17'd3);

        for (int p = 0; p < N_PHASES; p++) begin
            cfg_write(REG_GRID_SIZE, phase_grid[p]);
            cfg_write(REG_STEP_LIMIT, phase_limit[p]);
            tx_idle_on = phase_tx[p];
            rx_idle_on = phase_rx[p];
            for (int k = 0; k < PHASE_ITEMS; k++) push_random();
            if (p == HOLD_PHASE) hold_trigger = 1'b1;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("ran %0d steps and %0d bin reads across %0d register writes",
                 n_steps, n_reads, n_writes);
        $display("%0d walks finished, %0d of them on a meeting", n_ended, n_met);
        if (errors == 0) begin
            $display("PASS two_walker_meeting_histogram");
        end else begin
            $display("FAIL two_walker_meeting_histogram");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAIL two_walker_meeting_histogram");
        $finish;
    end

endmodule
